// File: src/tca_pkg.sv
// Shared types and codes for the thread core allocator.
// Holds the request/response transaction structs, operation codes, status codes and the controller state type.
// No dependencies.
package tca_pkg;

    typedef enum logic [1:0] {
        FUNC_SCHED = 2'd0,
        FUNC_SLEEP = 2'd1,
        FUNC_ERASE = 2'd2,
        FUNC_QUERY = 2'd3
    } t_func;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_NOT_EXEC  = 2'd1;
    localparam logic [1:0] STS_UNASSIGN  = 2'd2;
    localparam logic [1:0] STS_WAIT_FULL = 2'd3;

    typedef logic [3:0] t_tid;

    typedef struct packed {
        t_func func;
        t_tid  thread_num;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] query_core;
        logic       queued;
        logic       granted;
        t_tid       granted_thread;
        logic [1:0] granted_core;
        logic [3:0] granted_level;
    } t_rsp;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

endpackage

// File: src/thread_core_allocator_unit.sv
// Thread core allocator: free-core FIFO, wait queue and per-thread core table.
// Depends on tca_pkg for transaction structs, codes and state type.
//
// Usage:
//   Request channel: drive i_req with start high; the transaction is taken at
//   the rising edge where start is high and busy is low. busy is high for the
//   one execute cycle that follows.
//   Response channel: o_rsp is valid for exactly one cycle while o_strobe is
//   high; every request yields exactly one response. The receiver cannot
//   stall, so the response is presented once and then dropped.
//   Configuration: i_cfg_we with i_cfg_wdata writes the packed per-thread
//   frequency levels (thread n at bits 4n+3..4n). Write only while idle.
// Timing:
//   Accept edge issues the table and wait-queue reads; the next cycle does
//   the read-modify-write of all state; the response strobes the cycle after.
//   A new request is not taken in the execute cycle, while busy is high; the
//   core table and wait-queue memories have registered reads.
// Reset:
//   All cores free in order 0..NUM_CORES-1, wait queue empty, no thread
//   executing, sleeping or holding a core, frequency levels zero.
module thread_core_allocator_unit #(
    parameter int NUM_THREADS = 16,
    parameter int NUM_CORES   = 4,
    parameter int WAIT_DEPTH  = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  tca_pkg::t_req i_req,
    output logic          o_strobe,
    output tca_pkg::t_rsp o_rsp,
    input  logic          i_cfg_we,
    input  logic [63:0]   i_cfg_wdata
);
    import tca_pkg::*;

    localparam int TW   = $clog2(NUM_THREADS);
    localparam int CW   = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
    localparam int CNTW = $clog2(NUM_CORES + 1);
    localparam int CPW  = CNTW + 1;
    localparam int WW   = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int WCW  = $clog2(WAIT_DEPTH + 1);
    localparam int WPW  = WCW + 1;

    // control
    t_state r_state, n_state;
    logic   accept;
    logic   exec_en;

    // request and configuration
    t_req        r_req;
    logic [63:0] r_freq;

    // memories
    logic [CW-1:0] m_asg [NUM_THREADS];
    logic [CW-1:0] r_asg_rd;
    t_tid          m_wait [WAIT_DEPTH];
    t_tid          r_wait_rd;

    // flop state
    logic [NUM_THREADS-1:0] r_vld, n_vld;
    logic [NUM_THREADS-1:0] r_exec, n_exec;
    logic [NUM_THREADS-1:0] r_sleep, n_sleep;
    logic [CW-1:0]          r_free_fifo [NUM_CORES];
    logic [CW-1:0]          r_free_head, n_free_head;
    logic [CNTW-1:0]        r_free_cnt, n_free_cnt;
    logic [WW-1:0]          r_wait_head, n_wait_head;
    logic [WCW-1:0]         r_wait_cnt, n_wait_cnt;

    // response
    logic r_strobe;
    t_rsp r_rsp, n_rsp;

    // execute-cycle helpers
    logic          in_rng;
    logic [TW-1:0] idx;
    logic [CW-1:0] free_tail;
    logic [CPW-1:0] free_tail_sum;
    logic [WW-1:0] wait_tail;
    logic [WPW-1:0] wait_tail_sum;
    logic          fifo_we;
    logic          wq_we;
    logic          asg_we;
    logic [TW-1:0] asg_waddr;
    logic [CW-1:0] asg_wdata;
    logic          rel_en;
    logic          srv_en;
    logic          erase_clr;
    logic          give_en;
    t_tid          give_thr;
    logic [CW-1:0] give_core;
    logic [TW-1:0] give_idx;

    assign accept  = start && !busy;
    assign in_rng  = int'(r_req.thread_num) < NUM_THREADS;
    assign idx     = TW'(r_req.thread_num);

    assign free_tail_sum = CPW'(r_free_head) + CPW'(r_free_cnt);
    assign free_tail = (free_tail_sum >= CPW'(NUM_CORES))
                     ? CW'(free_tail_sum - CPW'(NUM_CORES)) : CW'(free_tail_sum);
    assign wait_tail_sum = WPW'(r_wait_head) + WPW'(r_wait_cnt);
    assign wait_tail = (wait_tail_sum >= WPW'(WAIT_DEPTH))
                     ? WW'(wait_tail_sum - WPW'(WAIT_DEPTH)) : WW'(wait_tail_sum);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) n_state = ST_EXEC;
            end
            ST_EXEC: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        busy    = 1'b0;
        exec_en = 1'b0;
        case (r_state)
            ST_IDLE: begin
                busy    = 1'b0;
                exec_en = 1'b0;
            end
            ST_EXEC: begin
                busy    = 1'b1;
                exec_en = 1'b1;
            end
            default: begin
                busy    = 1'b0;
                exec_en = 1'b0;
            end
        endcase
    end

    // read-modify-write of allocator state
    always_comb begin
        n_vld       = r_vld;
        n_exec      = r_exec;
        n_sleep     = r_sleep;
        n_free_head = r_free_head;
        n_free_cnt  = r_free_cnt;
        n_wait_head = r_wait_head;
        n_wait_cnt  = r_wait_cnt;
        fifo_we     = 1'b0;
        wq_we       = 1'b0;
        asg_we      = 1'b0;
        asg_waddr   = idx;
        asg_wdata   = r_asg_rd;
        rel_en      = 1'b0;
        srv_en      = 1'b0;
        erase_clr   = 1'b0;
        give_en     = 1'b0;
        give_thr    = r_req.thread_num;
        give_core   = r_free_fifo[r_free_head];
        give_idx    = idx;
        n_rsp       = '0;

        if (exec_en && in_rng) begin
            case (r_req.func)
                FUNC_SCHED: begin
                    if (!r_exec[idx]) begin
                        if (r_free_cnt != '0) begin
                            give_en    = 1'b1;
                            n_sleep[idx] = 1'b0;
                        end else if (r_wait_cnt < WCW'(WAIT_DEPTH)) begin
                            wq_we        = 1'b1;
                            n_wait_cnt   = r_wait_cnt + WCW'(1);
                            n_rsp.queued = 1'b1;
                            n_sleep[idx] = 1'b0;
                        end else begin
                            n_rsp.status = STS_WAIT_FULL;
                        end
                    end
                end
                FUNC_SLEEP: begin
                    if (!r_sleep[idx]) begin
                        n_sleep[idx] = 1'b1;
                        n_exec[idx]  = 1'b0;
                        rel_en       = 1'b1;
                    end
                    srv_en = 1'b1;
                end
                FUNC_ERASE: begin
                    if (r_exec[idx]) begin
                        rel_en    = 1'b1;
                        srv_en    = 1'b1;
                        erase_clr = 1'b1;
                    end else begin
                        n_rsp.status = STS_NOT_EXEC;
                    end
                end
                FUNC_QUERY: begin
                    if (r_vld[idx]) n_rsp.query_core = 2'(r_asg_rd);
                    else n_rsp.status = STS_UNASSIGN;
                end
                default: n_rsp = '0;
            endcase
        end

        // release the thread's core; drop it if the free FIFO is full
        if (rel_en && r_vld[idx]) begin
            n_vld[idx] = 1'b0;
            if (r_free_cnt < CNTW'(NUM_CORES)) begin
                fifo_we    = 1'b1;
                n_free_cnt = r_free_cnt + CNTW'(1);
            end
        end

        // hand a free core to the oldest waiting thread
        if (srv_en && r_wait_cnt != '0 && n_free_cnt != '0) begin
            n_wait_head = (r_wait_head == WW'(WAIT_DEPTH - 1)) ? '0 : r_wait_head + WW'(1);
            n_wait_cnt  = r_wait_cnt - WCW'(1);
            if (int'(r_wait_rd) < NUM_THREADS) begin
                give_en   = 1'b1;
                give_thr  = r_wait_rd;
                give_idx  = TW'(r_wait_rd);
                // an empty FIFO before the release means the head is the pushed core
                give_core = (r_free_cnt == '0) ? r_asg_rd : r_free_fifo[r_free_head];
            end
        end

        if (give_en) begin
            n_free_head          = (r_free_head == CW'(NUM_CORES - 1)) ? '0
                                                                       : r_free_head + CW'(1);
            n_free_cnt           = n_free_cnt - CNTW'(1);
            asg_we               = 1'b1;
            asg_waddr            = give_idx;
            asg_wdata            = give_core;
            n_vld[give_idx]      = 1'b1;
            n_exec[give_idx]     = 1'b1;
            n_rsp.granted        = 1'b1;
            n_rsp.granted_thread = give_thr;
            n_rsp.granted_core   = 2'(give_core);
            n_rsp.granted_level  = r_freq[{give_thr, 2'b00} +: 4];
        end

        // erase clears the executing bit after any hand-off
        if (erase_clr) n_exec[idx] = 1'b0;
    end

    // control and flop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_freq      <= '0;
            r_vld       <= '0;
            r_exec      <= '0;
            r_sleep     <= '0;
            r_free_head <= '0;
            r_free_cnt  <= CNTW'(NUM_CORES);
            r_wait_head <= '0;
            r_wait_cnt  <= '0;
            r_strobe    <= 1'b0;
            for (int i = 0; i < NUM_CORES; i++) begin
                r_free_fifo[i] <= CW'(i);
            end
        end else begin
            r_state     <= n_state;
            r_vld       <= n_vld;
            r_exec      <= n_exec;
            r_sleep     <= n_sleep;
            r_free_head <= n_free_head;
            r_free_cnt  <= n_free_cnt;
            r_wait_head <= n_wait_head;
            r_wait_cnt  <= n_wait_cnt;
            r_strobe    <= exec_en;
            if (i_cfg_we) r_freq <= i_cfg_wdata;
            if (fifo_we) r_free_fifo[free_tail] <= r_asg_rd;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) r_req <= i_req;
        if (exec_en) r_rsp <= n_rsp;
    end

    // core table memory
    always_ff @(posedge i_clk) begin
        if (asg_we) m_asg[asg_waddr] <= asg_wdata;
        if (accept) r_asg_rd <= m_asg[TW'(i_req.thread_num)];
    end

    // wait queue memory
    always_ff @(posedge i_clk) begin
        if (wq_we) m_wait[wait_tail] <= r_req.thread_num;
        if (accept) r_wait_rd <= m_wait[r_wait_head];
    end

    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule
